[rtl/longest_nondecreasing_subsequence_macros.svh]
// Assertion helpers for the checker file.
`ifndef LONGEST_NONDECREASING_SUBSEQUENCE_MACROS_SVH
`define LONGEST_NONDECREASING_SUBSEQUENCE_MACROS_SVH

// Same-cycle implication.
`define LNS_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define LNS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/lns_pkg.sv]
package lns_pkg;

   localparam int MAX_LEN_DEFAULT = 64;
   localparam int VALUE_W         = 16;
   localparam int LEN_W           = 7;
   localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic finish;
   } lns_cmd_type;

   typedef struct packed {
      logic empty;
      logic last;
   } lns_sts_type;

endpackage

[rtl/lns_ctrl.sv]
module lns_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  lns_pkg::lns_sts_type sts,
   output lns_pkg::lns_cmd_type cmd
);
   import lns_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = sts.empty ? ST_WRITE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      cmd.load   = 1'b0;
      cmd.rd_en  = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_SCAN:  cmd.rd_en  = 1'b1;
         ST_DRAIN: ;
         ST_WRITE: cmd.finish = 1'b1;
         default:  ;
      endcase
   end

endmodule

[rtl/lns_dp.sv]
module lns_dp #(
   parameter int MAX_LEN = lns_pkg::MAX_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic signed [lns_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_start_req,
   input  lns_pkg::lns_cmd_type              cmd,
   output lns_pkg::lns_sts_type              sts,
   output logic                              rsp_strobe,
   output logic [lns_pkg::LEN_W-1:0]         rsp_length_here,
   output logic [lns_pkg::LEN_W-1:0]         rsp_best_length,
   output logic                              rsp_overflow
);
   import lns_pkg::*;

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ENTRY_W = VALUE_W + LEN_W;

   // store entry: {value, length}
   logic [ENTRY_W-1:0] mem [MAX_LEN];

   logic signed [VALUE_W-1:0] val_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [LEN_W-1:0]          best_ff, best_in;
   logic [LEN_W-1:0]          prev_ff, prev_in;
   logic [ADDR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic                      cmp_valid_ff;
   logic [ENTRY_W-1:0]        rd_data_ff;

   logic                      strobe_ff;
   logic [LEN_W-1:0]          len_out_ff, best_out_ff;
   logic                      ovf_out_ff;

   logic signed [VALUE_W-1:0] rd_val;
   logic [LEN_W-1:0]          rd_len;
   logic [LEN_W-1:0]          len_new;
   logic [CNT_W-1:0]          cnt_m1;
   logic                      full;

   assign rd_val  = $signed(rd_data_ff[ENTRY_W-1:LEN_W]);
   assign rd_len  = rd_data_ff[LEN_W-1:0];
   assign len_new = (prev_ff == LEN_SAT) ? LEN_SAT : prev_ff + LEN_W'(1);
   assign cnt_m1  = count_ff - CNT_W'(1);
   assign full    = (count_ff == CNT_W'(MAX_LEN));

   assign sts.empty = req_start_req || (count_ff == '0);
   assign sts.last  = (CNT_W'(rd_addr_ff) == cnt_m1);

   always_comb begin
      count_in   = count_ff;
      best_in    = best_ff;
      prev_in    = prev_ff;
      rd_addr_in = rd_addr_ff;
      if (cmd.load) begin
         prev_in    = '0;
         rd_addr_in = '0;
         if (req_start_req) begin
            count_in = '0;
            best_in  = '0;
         end
      end
      if (cmd.rd_en) begin
         rd_addr_in = rd_addr_ff + ADDR_W'(1);
      end
      // read data arrives in the cycle after its address
      if (cmp_valid_ff && (rd_val <= val_ff) && (rd_len > prev_ff)) begin
         prev_in = rd_len;
      end
      if (cmd.finish) begin
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (len_new > best_ff) begin
            best_in = len_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
      if (cmd.finish && !full) begin
         mem[count_ff[ADDR_W-1:0]] <= {val_ff, len_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         best_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         count_ff     <= count_in;
         best_ff      <= best_in;
         cmp_valid_ff <= cmd.rd_en;
         strobe_ff    <= cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff    <= prev_in;
      rd_addr_ff <= rd_addr_in;
      if (cmd.load) begin
         val_ff <= req_value;
      end
      if (cmd.finish) begin
         len_out_ff  <= len_new;
         best_out_ff <= (len_new > best_ff) ? len_new : best_ff;
         ovf_out_ff  <= full;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_length_here = len_out_ff;
   assign rsp_best_length = best_out_ff;
   assign rsp_overflow    = ovf_out_ff;

endmodule

[rtl/longest_nondecreasing_subsequence.sv]
// Channel   Ports                                           Handshake
// request   req_value, req_start_req                        start & !busy
// response  rsp_length_here, rsp_best_length, rsp_overflow  rsp_strobe, one cycle
//
// An item holds busy high through a scan of the n stored entries (1 to MAX_LEN),
// one read of the entry store per cycle, then through the drain and write states.
// With an empty store or a start request only the write state remains.
// rsp_strobe is high in the first cycle with busy low again.
// Reset clears the stored count and running best; store contents are left as is.
// The receiver cannot stall: each result is shown for exactly one cycle.
module longest_nondecreasing_subsequence #(
   parameter int MAX_LEN = lns_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [lns_pkg::VALUE_W-1:0] req_value,
   input  logic                               req_start_req,
   output logic                               rsp_strobe,
   output logic [lns_pkg::LEN_W-1:0]          rsp_length_here,
   output logic [lns_pkg::LEN_W-1:0]          rsp_best_length,
   output logic                               rsp_overflow
);
   import lns_pkg::*;

   lns_cmd_type cmd;
   lns_sts_type sts;

   lns_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   lns_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_value       (req_value),
      .req_start_req   (req_start_req),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_length_here (rsp_length_here),
      .rsp_best_length (rsp_best_length),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

[rtl/lns_checker.sv]
`include "longest_nondecreasing_subsequence_macros.svh"

module lns_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               start,
   input logic                               busy,
   input logic signed [lns_pkg::VALUE_W-1:0] req_value,
   input logic                               req_start_req,
   input logic                               rsp_strobe,
   input logic [lns_pkg::LEN_W-1:0]          rsp_length_here,
   input logic [lns_pkg::LEN_W-1:0]          rsp_best_length,
   input logic                               rsp_overflow
);
   import lns_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_value, req_start_req, rsp_overflow};

   `LNS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accepted item did not raise busy")
   `LNS_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe longer than one cycle")
   `LNS_ASSERT_NOW(a_strobe_after_busy, clock, reset, rsp_strobe, $past(busy) && !busy, "result without a finished item")
   `LNS_ASSERT_NOW(a_len_bound, clock, reset, rsp_strobe, (rsp_length_here != '0) && (rsp_length_here <= rsp_best_length), "length exceeds running best")

endmodule

bind longest_nondecreasing_subsequence lns_checker u_lns_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import lns_pkg::*;

   localparam int STORE_DEPTH = MAX_LEN_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_LIMIT = 5000;

   typedef struct packed {
      logic [LEN_W-1:0] length_here;
      logic [LEN_W-1:0] best_length;
      logic             overflow;
   } score_type;

   typedef enum int {
      MODE_FULL,
      MODE_CLUSTER,
      MODE_RAMP,
      MODE_EXTREME
   } value_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value;
   logic                      req_start_req;
   logic                      rsp_strobe;
   logic [LEN_W-1:0]          rsp_length_here;
   logic [LEN_W-1:0]          rsp_best_length;
   logic                      rsp_overflow;

   // scorer model state
   logic signed [VALUE_W-1:0] seq_value [STORE_DEPTH];
   logic [LEN_W-1:0]          seq_length [STORE_DEPTH];
   int unsigned               seq_count;
   logic [LEN_W-1:0]          best_so_far;

   score_type   pending_scores[$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit          idle_on;
   int          ramp_level;

   longest_nondecreasing_subsequence dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .req_start_req   (req_start_req),
      .rsp_strobe      (rsp_strobe),
      .rsp_length_here (rsp_length_here),
      .rsp_best_length (rsp_best_length),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40)
         $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic score_type score_value(input logic signed [VALUE_W-1:0] value,
                                             input logic clear);
      score_type        s;
      logic [LEN_W-1:0] best_prev;
      if (clear) begin
         seq_count = 0;
         best_so_far = '0;
      end
      best_prev = '0;
      for (int i = 0; i < seq_count; i++)
         if (seq_value[i] <= value && seq_length[i] > best_prev)
            best_prev = seq_length[i];
      s.length_here = (best_prev >= LEN_SAT) ? LEN_SAT : best_prev + 1'b1;
      if (seq_count < STORE_DEPTH) begin
         seq_value[seq_count] = value;
         seq_length[seq_count] = s.length_here;
         seq_count++;
         s.overflow = 1'b0;
      end else begin
         s.overflow = 1'b1;
      end
      if (s.length_here > best_so_far)
         best_so_far = s.length_here;
      s.best_length = best_so_far;
      return s;
   endfunction

   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_scores.size() == 0) begin
            report_mismatch("result with nothing pending", 1, 0);
         end else begin
            want = pending_scores.pop_front();
            if (rsp_length_here !== want.length_here)
               report_mismatch("length_here", rsp_length_here, want.length_here);
            if (rsp_best_length !== want.best_length)
               report_mismatch("best_length", rsp_best_length, want.best_length);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
         end
      end
   end

   // start stays high across back-to-back items; only a gap or a drain wait lowers it
   task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic clear);
      start <= 1'b1;
      req_value <= value;
      req_start_req <= clear;
      do @(posedge clock); while (busy !== 1'b0);
      pending_scores.push_back(score_value(value, clear));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         // sometimes line the gap up with the end of the item
         if ($urandom_range(0, 1))
            do @(posedge clock); while (busy !== 1'b0);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic wait_for_scores();
      int guard;
      guard = 0;
      start <= 1'b0;
      while (pending_scores.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(input value_mode_type mode);
      int v;
      case (mode)
         MODE_FULL:    v = int'($urandom_range(0, 65535)) - 32768;
         MODE_CLUSTER: v = int'($urandom_range(0, 6)) - 3;
         MODE_RAMP: begin
            if ($urandom_range(0, 7) == 0)
               ramp_level = ramp_level - int'($urandom_range(0, 2000));
            else
               ramp_level = ramp_level + int'($urandom_range(0, 400));
            if (ramp_level > 32767) ramp_level = 32767;
            if (ramp_level < -32768) ramp_level = -32768;
            v = ramp_level;
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = -1;
               3:       v = 0;
               default: v = 1;
            endcase
         end
      endcase
      return VALUE_W'(v);
   endfunction

   // mostly clean sequences opened by a start; some broken or pure noise
   task automatic run_sequences(input int count);
      int             sent;
      int             seq_len;
      bit             noisy;
      logic           clear;
      value_mode_type mode;
      sent = 0;
      while (sent < count) begin
         seq_len = $urandom_range(0, 3) == 0 ? $urandom_range(60, 90) : $urandom_range(1, 70);
         mode = value_mode_type'($urandom_range(0, 3));
         noisy = ($urandom_range(0, 7) == 0);
         ramp_level = -32768 + int'($urandom_range(0, 2000));
         for (int k = 0; k < seq_len && sent < count; k++) begin
            if (noisy)
               clear = ($urandom_range(0, 7) == 0);
            else if ($urandom_range(0, 31) == 0)
               clear = 1'($urandom_range(0, 1));
            else
               clear = (k == 0);
            send_item(pick_value(mode), clear);
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      send_item(-16'sd32768, 1'b0);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd32767, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(-16'sd1, 1'b0);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd32767, 1'b0);
      send_item(16'sd5, 1'b1);
      send_item(16'sd5, 1'b0);
      send_item(16'sd4, 1'b0);
      send_item(16'sd6, 1'b0);
      send_item(16'sd100, 1'b1);
      send_item(-16'sd100, 1'b0);
      send_item(16'sd7, 1'b1);
      send_item(16'sd7, 1'b1);
      send_item(16'sh5555, 1'b0);
      send_item(16'shAAAA, 1'b0);
      send_item(16'sh5555, 1'b0);
      send_item(16'sh7FFF, 1'b0);
      send_item(16'sh8000, 1'b0);
   endtask

   // fill the store with a rising run, then score past the end
   task automatic test_store_full();
      for (int i = 0; i < STORE_DEPTH; i++)
         send_item(VALUE_W'(i * 500 - 32768), i == 0);
      send_item(16'sd32767, 1'b0);
      send_item(-16'sd32768, 1'b0);
      send_item(16'sd0, 1'b0);
      send_item(16'sd32767, 1'b0);
      send_item(16'sd0, 1'b1);
      send_item(16'sd1, 1'b0);
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 5; i++)
         send_item(pick_value(MODE_FULL), i == 0);
      wait_for_scores();
      for (int i = 0; i < 5; i++)
         send_item(pick_value(MODE_CLUSTER), 1'b0);
      wait_for_scores();
   endtask

   task automatic test_random_sequences();
      idle_on = 1'b1;
      run_sequences(1390);
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      run_sequences(160);
   endtask

   initial begin
      start <= 1'b0;
      req_value <= '0;
      req_start_req <= 1'b0;
      reset <= 1'b1;
      seq_count = 0;
      best_so_far = '0;
      ramp_level = 0;
      idle_on = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_store_full();
      test_drain_pause();
      test_random_sequences();
      test_back_to_back();

      wait_for_scores();
      repeat (80) @(posedge clock);
      if (pending_scores.size() != 0)
         report_mismatch("results never arrived", 0, pending_scores.size());
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/lns_pkg.sv
rtl/lns_ctrl.sv
rtl/lns_dp.sv
rtl/longest_nondecreasing_subsequence.sv
rtl/lns_checker.sv
test/testbench.sv
